// ===== hw/rtl/rcfd_pkg.sv =====
// ----------------------------------------------------------------------------
// rcfd_pkg
// Shared types and constants for the RC channel frame decoder.
// ----------------------------------------------------------------------------
package rcfd_pkg;

  localparam int CHANNELS_DEF = 14;
  localparam int QUEUE_DEPTH  = 4;

  localparam int BYTE_W = 8;
  localparam int IDX_W  = 4;
  localparam int VAL_W  = 12;
  localparam int SUM_W  = 16;
  localparam int POS_W  = 5;

  localparam logic [BYTE_W-1:0] HDR0    = 8'h20;
  localparam logic [BYTE_W-1:0] HDR1    = 8'h40;
  localparam logic [SUM_W-1:0]  HDR_SUM = 16'h0060;

  localparam logic [POS_W-1:0] POS_HDR0    = 5'd0;
  localparam logic [POS_W-1:0] POS_HDR1    = 5'd1;
  localparam logic [POS_W-1:0] POS_PAYLOAD = 5'd2;
  localparam logic [POS_W-1:0] POS_CSUM_LO = 5'd30;
  localparam logic [POS_W-1:0] POS_CSUM_HI = 5'd31;

  typedef enum logic {
    CMD_WRITE,
    CMD_FRAME
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [IDX_W-1:0]   idx;
    logic [VAL_W-1:0]   val;
    logic               ok;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== hw/rtl/rc_channel_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// rc_channel_frame_decoder
// Frames 32-byte RC receiver frames, checks the checksum and emits the
// decoded channel values.
// ----------------------------------------------------------------------------
// Receiver bytes are taken one per cycle while the four-entry command queue
// has room; a byte never waits on the result side unless that queue fills.
// A frame with a good checksum yields CHANNELS results, one per cycle while
// out_stall is low, from the single output register, once its frame-end
// command has passed through the queue and the emitter; a bad frame yields
// one failure word. The back end executes channel writes and frame ends from
// the queue in order; while it emits a frame's results it takes no further
// commands, so the queue can fill and the receiver bytes can be stalled.
module rc_channel_frame_decoder import rcfd_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_rx_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [IDX_W-1:0]  out_channel_index,
  output logic [VAL_W-1:0]  out_channel_value,
  output logic              out_frame_ok,
  output logic              out_last
);

  q_status_t q_status;
  logic      push;
  cmd_t      push_cmd;
  logic      pop;
  cmd_t      pop_cmd;

  rcfd_front #(.CHANNELS(CHANNELS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .q_status   (q_status),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  rcfd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .status   (q_status)
  );

  rcfd_back #(.CHANNELS(CHANNELS)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_status          (q_status),
    .pop_cmd           (pop_cmd),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_channel_index (out_channel_index),
    .out_channel_value (out_channel_value),
    .out_frame_ok      (out_frame_ok),
    .out_last          (out_last)
  );

endmodule

// ===== hw/rtl/rcfd_front.sv =====
// ----------------------------------------------------------------------------
// rcfd_front
// Byte framer: hunts the header, sums the payload, checks the checksum and
// issues channel-write and frame-end commands.
// ----------------------------------------------------------------------------
module rcfd_front import rcfd_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_rx_byte,
  input  q_status_t         q_status,
  output logic              push,
  output cmd_t              push_cmd
);

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [BYTE_W-1:0] low_r, low_nxt;
  logic [BYTE_W-1:0] csum_lo_r, csum_lo_nxt;
  logic              accept;
  logic [IDX_W-1:0]  ch;
  logic [SUM_W-1:0]  expected;
  logic [SUM_W-1:0]  received;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !q_status.full;
  assign ch       = pos_r[POS_W-1:1] - IDX_W'(1);
  assign expected = ~(sum_r + HDR_SUM);
  assign received = {in_rx_byte, csum_lo_r};

  always_comb begin
    pos_nxt     = pos_r;
    sum_nxt     = sum_r;
    low_nxt     = low_r;
    csum_lo_nxt = csum_lo_r;
    push        = 1'b0;
    push_cmd    = '{kind: CMD_WRITE, idx: ch, val: {in_rx_byte[3:0], low_r}, ok: 1'b0};
    if (accept) begin
      priority if (pos_r == POS_HDR0) begin
        if (in_rx_byte == HDR0) pos_nxt = POS_HDR1;
      end else if (pos_r == POS_HDR1) begin
        if (in_rx_byte == HDR1) begin
          pos_nxt = POS_PAYLOAD;
          sum_nxt = '0;
        end else begin
          pos_nxt = POS_HDR0;
        end
      end else if (pos_r < POS_CSUM_LO) begin
        sum_nxt = sum_r + SUM_W'(in_rx_byte);
        pos_nxt = pos_r + POS_W'(1);
        if (!pos_r[0]) begin
          low_nxt = in_rx_byte;
        end else if (ch < IDX_W'(CHANNELS)) begin
          push = 1'b1;
        end
      end else if (pos_r == POS_CSUM_LO) begin
        csum_lo_nxt = in_rx_byte;
        pos_nxt     = POS_CSUM_HI;
      end else begin
        pos_nxt       = POS_HDR0;
        push          = 1'b1;
        push_cmd.kind = CMD_FRAME;
        push_cmd.ok   = (received == expected);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_HDR0;
      sum_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
    end
    low_r     <= low_nxt;
    csum_lo_r <= csum_lo_nxt;
  end

endmodule

// ===== hw/rtl/rcfd_queue.sv =====
// ----------------------------------------------------------------------------
// rcfd_queue
// Small command FIFO between the framer and the result emitter.
// ----------------------------------------------------------------------------
module rcfd_queue import rcfd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cmd_t      push_cmd,
  input  logic      pop,
  output cmd_t      pop_cmd,
  output q_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign status.full  = (count_r == CNT_W'(DEPTH));
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_cmd      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
    if (do_push) mem_r[wr_ptr_r] <= push_cmd;
  end

endmodule

// ===== hw/rtl/rcfd_back.sv =====
// ----------------------------------------------------------------------------
// rcfd_back
// Result emitter: holds the channel store, executes queued commands and
// drives the registered result word.
// ----------------------------------------------------------------------------
module rcfd_back import rcfd_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  q_status_t        q_status,
  input  cmd_t             pop_cmd,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [IDX_W-1:0] out_channel_index,
  output logic [VAL_W-1:0] out_channel_value,
  output logic             out_frame_ok,
  output logic             out_last
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [VAL_W-1:0] store_r [CHANNELS];
  logic             emitting_r;
  logic [IDX_W-1:0] cnt_r;
  logic             out_valid_r;
  logic [IDX_W-1:0] idx_r;
  logic [VAL_W-1:0] val_r;
  logic             ok_r;
  logic             last_r;
  logic             out_free;
  logic             cnt_last;
  logic             emit_word;
  logic             fail_word;

  assign out_free  = !out_valid_r || !out_stall;
  assign cnt_last  = (cnt_r == IDX_W'(CHANNELS - 1));
  assign pop       = !q_status.empty && !emitting_r &&
                     ((pop_cmd.kind == CMD_WRITE) || out_free);
  assign emit_word = emitting_r && out_free;
  assign fail_word = pop && (pop_cmd.kind == CMD_FRAME) && !pop_cmd.ok;

  assign out_valid         = out_valid_r;
  assign out_channel_index = idx_r;
  assign out_channel_value = val_r;
  assign out_frame_ok      = ok_r;
  assign out_last          = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      emitting_r  <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (emit_word || fail_word) begin
        out_valid_r <= 1'b1;
      end else if (out_free) begin
        out_valid_r <= 1'b0;
      end
      if (emitting_r) begin
        if (out_free) begin
          cnt_r <= cnt_r + IDX_W'(1);
          if (cnt_last) emitting_r <= 1'b0;
        end
      end else if (pop && pop_cmd.kind == CMD_FRAME && pop_cmd.ok) begin
        emitting_r <= 1'b1;
        cnt_r      <= '0;
      end
    end
    if (emit_word) begin
      idx_r  <= cnt_r;
      val_r  <= store_r[cnt_r[CH_W-1:0]];
      ok_r   <= 1'b1;
      last_r <= cnt_last;
    end else if (fail_word) begin
      idx_r  <= '0;
      val_r  <= '0;
      ok_r   <= 1'b0;
      last_r <= 1'b1;
    end
    if (pop && pop_cmd.kind == CMD_WRITE) begin
      store_r[pop_cmd.idx[CH_W-1:0]] <= pop_cmd.val;
    end
  end

endmodule

// ===== hw/rtl/rcfd_checker.sv =====
// ----------------------------------------------------------------------------
// rcfd_checker
// Port-level checks on the decoder's result stream.
// ----------------------------------------------------------------------------
module rcfd_checker import rcfd_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_stall,
  input logic [IDX_W-1:0] out_channel_index,
  input logic [VAL_W-1:0] out_channel_value,
  input logic             out_frame_ok,
  input logic             out_last
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_channel_index) &&
      $stable(out_channel_value) && $stable(out_frame_ok) && $stable(out_last))
    else $error("stalled result word changed");

  a_fail_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_ok |-> out_last && out_channel_index == '0 &&
      out_channel_value == '0)
    else $error("failure word malformed");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_ok |->
      (out_last == (out_channel_index == IDX_W'(CHANNELS - 1))))
    else $error("last flag does not match final channel");

  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_frame_ok && !out_last ##1 out_valid |->
      out_frame_ok && out_channel_index == $past(out_channel_index) + IDX_W'(1))
    else $error("channel index did not advance");

endmodule

bind rc_channel_frame_decoder rcfd_checker #(.CHANNELS(CHANNELS)) u_rcfd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_channel_index (out_channel_index),
  .out_channel_value (out_channel_value),
  .out_frame_ok      (out_frame_ok),
  .out_last          (out_last)
);
